// ===== hdl/tmt_pkg.sv =====
// Shared types, widths and codes for the multi-turn encoder tracker.
package tmt_pkg;

  localparam int ANGLE_W    = 14;
  localparam int STEP_W     = 32;
  localparam int DIST_W     = 36;
  localparam int CIRC_W     = 18;
  localparam int DIR_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int CAL_CNT_W  = 7;
  localparam int CAL_SUM_W  = 20;
  localparam int CAL_SQ_W   = 34;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;

  // Fixed point: one turn is 2^FRAC_W steps.
  localparam int FRAC_W = 14;

  // Threshold search widths.
  localparam int TH_W   = 41;  // n * sum of squares
  localparam int TGT_W  = 45;  // 9 * variance term
  localparam int TN_W   = 21;  // mid * n
  localparam int SRCH_W = 15;  // search bounds, 0..16384

  // Shared shift-add multiplier.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 21;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CAL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FAIL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_DIRECTION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CIRCUMFERENCE   = 1'd1;

  localparam logic [ANGLE_W-1:0] DEADBAND_RESET = 14'd5;
  localparam logic [ANGLE_W-1:0] DEADBAND_MIN   = 14'd3;
  localparam logic [ANGLE_W-1:0] DEADBAND_MAX   = 14'd16383;
  localparam logic [SRCH_W-1:0]  SEARCH_HI      = 15'd16384;

  localparam logic signed [15:0] HALF_TURN  = 16'sd8192;
  localparam logic signed [15:0] TURN_STEPS = 16'sd16384;

  typedef struct packed {
    logic               req_type;
    logic               read_ok;
    logic [ANGLE_W-1:0] angle;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [STEP_W-1:0] step_total;
    logic signed [STEP_W-1:0] turn_count;
    logic signed [DIST_W-1:0] distance_um;
    logic [ANGLE_W-1:0]       noise_limit;
    logic                     calibrated;
  } out_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

endpackage

// ===== hdl/encoder_multiturn_tracker.sv =====
// Multi-turn rotary encoder tracker: calibration, unwrap, deadband and distance.
//
// Takes 14-bit absolute angle samples (16384 steps per turn) and re-zero
// requests, one result per input transfer. The first CAL_SAMPLES good
// tracking samples only build a sum and a sum of squares; the next good
// sample sets the noise deadband to the smallest integer t with
// t >= max(3 * stddev, 3), saturated at 16383, and is then tracked.
// Tracking unwraps each move at half a turn and drops moves below the
// deadband; accepted moves update the reference, the step total and the
// turn count. Distance is step total * circumference / 16384, truncated
// toward zero. One item is processed at a time. All multiplies go through
// one shift-add multiplier that retires one multiplier bit per cycle, so the
// time a transfer takes grows with the bit lengths of its multipliers: that
// of circumference_um for a tracked, failed or re-zero transfer, and for a
// calibration sample also that of its angle.
// The sample that closes calibration runs a binary search of up to 15 steps
// for the threshold, two serial multiplies per step. A finished result sits
// in an output register until taken; the block waits there only if the
// previous result is still pending.
// Configuration writes take effect at once and are meant for idle periods.
module encoder_multiturn_tracker #(
  parameter int CAL_SAMPLES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tmt_pkg::in_t                     in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output tmt_pkg::out_t                    out_data,
  // configuration
  input  logic                             cfg_we,
  input  logic [tmt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tmt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Number of calibration samples as an operand.
  localparam logic [tmt_pkg::CAL_CNT_W-1:0] CAL_N = tmt_pkg::CAL_CNT_W'(CAL_SAMPLES);

  // Sequencer states
  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_DECODE     = 5'd1;
  localparam logic [4:0] S_CAL_MUL    = 5'd2;
  localparam logic [4:0] S_CAL_WAIT   = 5'd3;
  localparam logic [4:0] S_TH_A_MUL   = 5'd4;
  localparam logic [4:0] S_TH_A_WAIT  = 5'd5;
  localparam logic [4:0] S_TH_B_MUL   = 5'd6;
  localparam logic [4:0] S_TH_B_WAIT  = 5'd7;
  localparam logic [4:0] S_TH_TGT     = 5'd8;
  localparam logic [4:0] S_BS_CHK     = 5'd9;
  localparam logic [4:0] S_BS_TN_MUL  = 5'd10;
  localparam logic [4:0] S_BS_TN_WAIT = 5'd11;
  localparam logic [4:0] S_BS_SQ_MUL  = 5'd12;
  localparam logic [4:0] S_BS_SQ_WAIT = 5'd13;
  localparam logic [4:0] S_TRACK      = 5'd14;
  localparam logic [4:0] S_DIST_MUL   = 5'd15;
  localparam logic [4:0] S_DIST_WAIT  = 5'd16;
  localparam logic [4:0] S_PUSH       = 5'd17;

  logic [4:0] state_r, state_nxt;

  // configuration
  logic [tmt_pkg::DIR_W-1:0]  dir_r;
  logic [tmt_pkg::CIRC_W-1:0] circ_r;

  // tracking state
  tmt_pkg::in_t                  item_r;
  logic [tmt_pkg::ANGLE_W-1:0]   ref_r;
  logic                          have_ref_r;
  logic [tmt_pkg::STEP_W-1:0]    steps_r;
  logic [tmt_pkg::STEP_W-1:0]    turns_r;
  logic [tmt_pkg::CAL_CNT_W-1:0] cal_seen_r;
  logic [tmt_pkg::CAL_SUM_W-1:0] cal_sum_r;
  logic [tmt_pkg::CAL_SQ_W-1:0]  cal_sq_r;
  logic                          cal_done_r;
  logic [tmt_pkg::ANGLE_W-1:0]   deadband_r;
  logic [tmt_pkg::STATUS_W-1:0]  status_r;

  // threshold search scratch
  logic [tmt_pkg::TH_W-1:0]    th_a_r;
  logic [tmt_pkg::TH_W-1:0]    th_d_r;
  logic [tmt_pkg::TGT_W-1:0]   target_r;
  logic [tmt_pkg::SRCH_W-1:0]  lo_r;
  logic [tmt_pkg::SRCH_W-1:0]  hi_r;
  logic [tmt_pkg::ANGLE_W-1:0] mid_r;
  logic [tmt_pkg::TN_W-1:0]    tn_r;

  logic [tmt_pkg::DIST_W-1:0] dist_r;
  tmt_pkg::out_t              out_data_r;
  logic                       out_valid_r;

  tmt_pkg::mul_req_t mul_req;
  tmt_pkg::mul_rsp_t mul_rsp;

  logic                           in_xfer;
  logic                           push_ok;
  logic                           cal_more;
  logic [tmt_pkg::SRCH_W:0]       mid_sum;
  logic [tmt_pkg::STEP_W-1:0]     steps_abs;
  logic [tmt_pkg::DIST_W-1:0]     dist_mag;
  logic [tmt_pkg::TH_W-1:0]       th_b;
  logic [tmt_pkg::ANGLE_W-1:0]    lo_clamped;
  logic signed [15:0]             d_raw;
  logic signed [15:0]             d_unw;
  logic [15:0]                    d_mag;
  logic [tmt_pkg::STEP_W-1:0]     wrap_add;
  logic [tmt_pkg::STEP_W-1:0]     step_add;
  logic                           move_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign push_ok   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cal_more  = (cal_seen_r < CAL_N);
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign steps_abs = steps_r[tmt_pkg::STEP_W-1] ? (~steps_r + 1'b1) : steps_r;
  assign dist_mag  = mul_rsp.prod[tmt_pkg::FRAC_W +: tmt_pkg::DIST_W];
  assign th_b      = tmt_pkg::TH_W'(mul_rsp.prod[2*tmt_pkg::CAL_SUM_W-1:0]);

  // Search result clamped to [3, 16383].
  always_comb begin
    if (lo_r[tmt_pkg::SRCH_W-1]) begin
      lo_clamped = tmt_pkg::DEADBAND_MAX;
    end else if (lo_r[tmt_pkg::ANGLE_W-1:0] < tmt_pkg::DEADBAND_MIN) begin
      lo_clamped = tmt_pkg::DEADBAND_MIN;
    end else begin
      lo_clamped = lo_r[tmt_pkg::ANGLE_W-1:0];
    end
  end

  // Unwrap at half a turn; exactly +/- half a turn stays as is.
  always_comb begin
    d_raw    = signed'({2'b00, item_r.angle}) - signed'({2'b00, ref_r});
    d_unw    = d_raw;
    wrap_add = '0;
    if (d_raw > tmt_pkg::HALF_TURN) begin
      d_unw    = d_raw - tmt_pkg::TURN_STEPS;
      wrap_add = '1;
    end else if (d_raw < -tmt_pkg::HALF_TURN) begin
      d_unw    = d_raw + tmt_pkg::TURN_STEPS;
      wrap_add = tmt_pkg::STEP_W'(1);
    end
    d_mag    = d_unw[15] ? 16'(-d_unw) : 16'(d_unw);
    move_ok  = (d_mag >= {2'b00, deadband_r});
    step_add = {{(tmt_pkg::STEP_W-16){d_unw[15]}}, d_unw};
    // negative direction register counts backward
    if (dir_r[tmt_pkg::DIR_W-1]) begin
      step_add = ~step_add + 1'b1;
    end
  end

  // Multiplier operand selection
  always_comb begin
    mul_req = '0;
    case (state_r)
      S_CAL_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = tmt_pkg::MUL_A_W'(item_r.angle);
        mul_req.b     = tmt_pkg::MUL_B_W'(item_r.angle);
      end
      S_TH_A_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = cal_sq_r;
        mul_req.b     = tmt_pkg::MUL_B_W'(CAL_N);
      end
      S_TH_B_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = tmt_pkg::MUL_A_W'(cal_sum_r);
        mul_req.b     = tmt_pkg::MUL_B_W'(cal_sum_r);
      end
      S_BS_TN_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = tmt_pkg::MUL_A_W'(mid_r);
        mul_req.b     = tmt_pkg::MUL_B_W'(CAL_N);
      end
      S_BS_SQ_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = tmt_pkg::MUL_A_W'(tn_r);
        mul_req.b     = tn_r;
      end
      S_DIST_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = tmt_pkg::MUL_A_W'(steps_abs);
        mul_req.b     = tmt_pkg::MUL_B_W'(circ_r);
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  tmt_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (item_r.req_type || !item_r.read_ok) begin
          state_nxt = S_DIST_MUL;
        end else if (!cal_done_r && cal_more) begin
          state_nxt = S_CAL_MUL;
        end else if (!cal_done_r) begin
          state_nxt = S_TH_A_MUL;
        end else begin
          state_nxt = S_TRACK;
        end
      end
      S_CAL_MUL:    state_nxt = S_CAL_WAIT;
      S_CAL_WAIT: begin
        if (mul_rsp.done) state_nxt = S_DIST_MUL;
      end
      S_TH_A_MUL:   state_nxt = S_TH_A_WAIT;
      S_TH_A_WAIT: begin
        if (mul_rsp.done) state_nxt = S_TH_B_MUL;
      end
      S_TH_B_MUL:   state_nxt = S_TH_B_WAIT;
      S_TH_B_WAIT: begin
        if (mul_rsp.done) state_nxt = S_TH_TGT;
      end
      S_TH_TGT:     state_nxt = S_BS_CHK;
      S_BS_CHK: begin
        state_nxt = (lo_r < hi_r) ? S_BS_TN_MUL : S_TRACK;
      end
      S_BS_TN_MUL:  state_nxt = S_BS_TN_WAIT;
      S_BS_TN_WAIT: begin
        if (mul_rsp.done) state_nxt = S_BS_SQ_MUL;
      end
      S_BS_SQ_MUL:  state_nxt = S_BS_SQ_WAIT;
      S_BS_SQ_WAIT: begin
        if (mul_rsp.done) state_nxt = S_BS_CHK;
      end
      S_TRACK:      state_nxt = S_DIST_MUL;
      S_DIST_MUL:   state_nxt = S_DIST_WAIT;
      S_DIST_WAIT: begin
        if (mul_rsp.done) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (push_ok) state_nxt = S_IDLE;
      end
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= 2'sb01;
      circ_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tmt_pkg::CFG_COUNT_DIRECTION: dir_r  <= cfg_data[tmt_pkg::DIR_W-1:0];
        tmt_pkg::CFG_CIRCUMFERENCE:   circ_r <= cfg_data[tmt_pkg::CIRC_W-1:0];
        default: ;
      endcase
    end
  end

  // Tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r      <= '0;
      have_ref_r <= 1'b0;
      steps_r    <= '0;
      turns_r    <= '0;
      cal_seen_r <= '0;
      cal_sum_r  <= '0;
      cal_sq_r   <= '0;
      cal_done_r <= 1'b0;
      deadband_r <= tmt_pkg::DEADBAND_RESET;
      status_r   <= tmt_pkg::STATUS_OK;
    end else begin
      case (state_r)
        S_DECODE: begin
          if (item_r.req_type) begin
            // re-zero: totals clear, reference follows the read
            steps_r    <= '0;
            turns_r    <= '0;
            ref_r      <= item_r.read_ok ? item_r.angle : '0;
            have_ref_r <= item_r.read_ok;
            status_r   <= item_r.read_ok ? tmt_pkg::STATUS_OK : tmt_pkg::STATUS_FAIL;
          end else if (!item_r.read_ok) begin
            status_r <= tmt_pkg::STATUS_FAIL;
          end
        end
        S_CAL_WAIT: begin
          if (mul_rsp.done) begin
            cal_sum_r  <= cal_sum_r + tmt_pkg::CAL_SUM_W'(item_r.angle);
            cal_sq_r   <= cal_sq_r +
                          tmt_pkg::CAL_SQ_W'(mul_rsp.prod[2*tmt_pkg::ANGLE_W-1:0]);
            cal_seen_r <= cal_seen_r + 1'b1;
            status_r   <= tmt_pkg::STATUS_CAL;
            if (!have_ref_r) begin
              ref_r      <= item_r.angle;
              have_ref_r <= 1'b1;
            end
          end
        end
        S_BS_CHK: begin
          if (lo_r >= hi_r) begin
            deadband_r <= lo_clamped;
            cal_done_r <= 1'b1;
          end
        end
        S_TRACK: begin
          status_r <= tmt_pkg::STATUS_OK;
          if (!have_ref_r) begin
            ref_r      <= item_r.angle;
            have_ref_r <= 1'b1;
          end else if (move_ok) begin
            steps_r <= steps_r + step_add;
            turns_r <= turns_r + wrap_add;
            ref_r   <= item_r.angle;
          end
        end
        default: ;
      endcase
    end
  end

  // Item capture, threshold search and distance datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
    case (state_r)
      S_TH_A_WAIT: begin
        if (mul_rsp.done) th_a_r <= mul_rsp.prod[tmt_pkg::TH_W-1:0];
      end
      S_TH_B_WAIT: begin
        // variance term n*sum_sq - sum^2, floored at zero
        if (mul_rsp.done) th_d_r <= (th_a_r > th_b) ? (th_a_r - th_b) : '0;
      end
      S_TH_TGT: begin
        target_r <= tmt_pkg::TGT_W'({th_d_r, 3'b000}) + tmt_pkg::TGT_W'(th_d_r);
        lo_r     <= '0;
        hi_r     <= tmt_pkg::SEARCH_HI;
      end
      S_BS_CHK: begin
        mid_r <= mid_sum[tmt_pkg::ANGLE_W:1];
      end
      S_BS_TN_WAIT: begin
        if (mul_rsp.done) tn_r <= mul_rsp.prod[tmt_pkg::TN_W-1:0];
      end
      S_BS_SQ_WAIT: begin
        if (mul_rsp.done) begin
          if (tmt_pkg::TGT_W'(mul_rsp.prod[2*tmt_pkg::TN_W-1:0]) >= target_r) begin
            hi_r <= {1'b0, mid_r};
          end else begin
            lo_r <= {1'b0, mid_r} + 1'b1;
          end
        end
      end
      S_DIST_WAIT: begin
        // magnitude product shifted down, sign restored: truncates toward zero
        if (mul_rsp.done) begin
          dist_r <= steps_r[tmt_pkg::STEP_W-1] ? (~dist_mag + 1'b1) : dist_mag;
        end
      end
      S_PUSH: begin
        if (push_ok) begin
          out_data_r.status      <= status_r;
          out_data_r.step_total  <= steps_r;
          out_data_r.turn_count  <= turns_r;
          out_data_r.distance_um <= dist_r;
          out_data_r.noise_limit <= deadband_r;
          out_data_r.calibrated  <= cal_done_r;
        end
      end
      default: ;
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_PUSH && push_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== hdl/tmt_serial_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module tmt_serial_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  tmt_pkg::mul_req_t  req,
  output tmt_pkg::mul_rsp_t  rsp
);

  logic                        busy_r;
  logic [tmt_pkg::MUL_P_W-1:0] a_r;
  logic [tmt_pkg::MUL_B_W-1:0] b_r;
  logic [tmt_pkg::MUL_P_W-1:0] acc_r;
  logic                        last;

  // Finishes once the remaining multiplier bits are all zero.
  assign last = (b_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= tmt_pkg::MUL_P_W'(req.a);
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r && !last) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign rsp.done = busy_r && last;
  assign rsp.prod = acc_r;

endmodule

// ===== tb/tb_encoder_multiturn_tracker.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the multi-turn encoder tracker.
module tb_encoder_multiturn_tracker;

  localparam int CAL_N       = 64;
  localparam int STALL_LIMIT = 4000;  // cycles with no transfer before giving up

  // count_direction codes (2-bit signed register)
  localparam logic [tmt_pkg::DIR_W-1:0] DIR_FWD  = 2'b01;
  localparam logic [tmt_pkg::DIR_W-1:0] DIR_ZERO = 2'b00;
  localparam logic [tmt_pkg::DIR_W-1:0] DIR_BWD  = 2'b11;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  tmt_pkg::in_t                   in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  tmt_pkg::out_t                  out_data;
  logic                           cfg_we = 1'b0;
  logic [tmt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tmt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  encoder_multiturn_tracker #(
    .CAL_SAMPLES(CAL_N)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Samples waiting to be sent, and readings predicted for accepted samples.
  tmt_pkg::in_t  sample_q[$];
  tmt_pkg::out_t reading_q[$];

  int n_mismatch   = 0;
  int stall_cycles = 0;
  bit in_xfer_seen = 1'b0;  // set at the rising edge of an input transfer
  bit quiet_tail   = 1'b0;  // no idling on either side once set
  int in_gap = 0, in_calm = 0, out_gap = 0, out_calm = 0;

  // Shadow of the configuration registers, updated as writes land.
  logic [tmt_pkg::DIR_W-1:0]  dir_q  = DIR_FWD;
  logic [tmt_pkg::CIRC_W-1:0] circ_q = '0;

  // Shadow tracker state, reset values.
  logic [tmt_pkg::ANGLE_W-1:0]       trk_ref      = '0;
  bit                                trk_have_ref = 1'b0;
  logic signed [tmt_pkg::STEP_W-1:0] trk_steps    = '0;
  logic [tmt_pkg::STEP_W-1:0]        trk_turns    = '0;
  int                                trk_cal_seen = 0;
  logic [tmt_pkg::CAL_SUM_W-1:0]     trk_cal_sum  = '0;
  logic [tmt_pkg::CAL_SQ_W-1:0]      trk_cal_sq   = '0;
  bit                                trk_cal_done = 1'b0;
  logic [tmt_pkg::ANGLE_W-1:0]       trk_deadband = tmt_pkg::DEADBAND_RESET;

  // Advance the shadow tracker by one sample and return the reading it yields.
  function automatic tmt_pkg::out_t track_sample(tmt_pkg::in_t s);
    tmt_pkg::out_t                r;
    logic [tmt_pkg::STATUS_W-1:0] st;
    int                           d;
    int                           mag;
    logic [tmt_pkg::STEP_W-1:0]   wrap;
    logic [tmt_pkg::STEP_W-1:0]   ud;
    longint                       dist_um;
    longint unsigned              spread, sq, tgt, lo, hi, mid, scaled;
    st = tmt_pkg::STATUS_OK;
    if (s.req_type) begin
      // re-zero: totals clear, reference follows the read result
      trk_steps    = '0;
      trk_turns    = '0;
      trk_have_ref = s.read_ok;
      trk_ref      = s.read_ok ? s.angle : '0;
      st           = s.read_ok ? tmt_pkg::STATUS_OK : tmt_pkg::STATUS_FAIL;
    end else if (!s.read_ok) begin
      st = tmt_pkg::STATUS_FAIL;
    end else if (!trk_cal_done && trk_cal_seen < CAL_N) begin
      trk_cal_sum  = trk_cal_sum + s.angle;
      trk_cal_sq   = trk_cal_sq + s.angle * s.angle;
      trk_cal_seen = trk_cal_seen + 1;
      if (!trk_have_ref) begin
        trk_ref      = s.angle;
        trk_have_ref = 1'b1;
      end
      st = tmt_pkg::STATUS_CAL;
    end else begin
      if (!trk_cal_done) begin
        // smallest t with (t*n)^2 >= 9*(n*sumsq - sum^2), clamped to [3, 16383]
        spread = trk_cal_sq * CAL_N;
        sq     = trk_cal_sum * trk_cal_sum;
        spread = (spread > sq) ? spread - sq : 0;
        tgt    = 9 * spread;
        lo     = 0;
        hi     = tmt_pkg::SEARCH_HI;
        while (lo < hi) begin
          mid    = (lo + hi) / 2;
          scaled = mid * CAL_N;
          if (scaled * scaled >= tgt) hi = mid;
          else lo = mid + 1;
        end
        if (lo > tmt_pkg::DEADBAND_MAX) lo = tmt_pkg::DEADBAND_MAX;
        if (lo < tmt_pkg::DEADBAND_MIN) lo = tmt_pkg::DEADBAND_MIN;
        trk_deadband = lo[tmt_pkg::ANGLE_W-1:0];
        trk_cal_done = 1'b1;
      end
      if (!trk_have_ref) begin
        trk_ref      = s.angle;
        trk_have_ref = 1'b1;
      end else begin
        // unwrap at half a turn; exactly +/-half stays as is
        d    = int'(s.angle) - int'(trk_ref);
        wrap = '0;
        if (d > tmt_pkg::HALF_TURN) begin
          d    = d - tmt_pkg::TURN_STEPS;
          wrap = '1;
        end else if (d < -tmt_pkg::HALF_TURN) begin
          d    = d + tmt_pkg::TURN_STEPS;
          wrap = 1;
        end
        mag = (d < 0) ? -d : d;
        // turns only move together with an accepted step
        if (mag >= trk_deadband) begin
          ud = d;
          if (dir_q[tmt_pkg::DIR_W-1]) ud = -ud;
          trk_steps = trk_steps + ud;
          trk_turns = trk_turns + wrap;
          trk_ref   = s.angle;
        end
      end
    end
    dist_um       = (longint'(trk_steps) * longint'(circ_q)) / 16384;
    r.status      = st;
    r.step_total  = trk_steps;
    r.turn_count  = trk_turns;
    r.distance_um = dist_um[tmt_pkg::DIST_W-1:0];
    r.noise_limit = trk_deadband;
    r.calibrated  = trk_cal_done;
    return r;
  endfunction

  function automatic tmt_pkg::in_t sample_item(bit req, bit ok,
                                               logic [tmt_pkg::ANGLE_W-1:0] ang);
    tmt_pkg::in_t s;
    s.req_type = req;
    s.read_ok  = ok;
    s.angle    = ang;
    return s;
  endfunction

  // Random angle anywhere on the turn.
  function automatic logic [tmt_pkg::ANGLE_W-1:0] any_angle();
    return tmt_pkg::ANGLE_W'($urandom_range(0, 16383));
  endfunction

  // Random idle burst, with calm stretches of no idling.
  function automatic int pick_gap(inout int calm);
    if (quiet_tail) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic cmp_field(input string name, input logic [63:0] want_v,
                           input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(want_v), $signed(got_v));
      n_mismatch++;
    end
  endtask

  task automatic cfg_write(input logic [tmt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tmt_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Block is idle: nothing queued, nothing in flight, no reading outstanding.
  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid || reading_q.size() != 0) @(posedge clk);
  endtask

  // Sender: loads the next sample after a transfer, holds it until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer_seen) begin
      in_xfer_seen = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        in_data  <= sample_q.pop_front();
        in_valid <= 1'b1;
        in_gap    = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap    = pick_gap(out_calm);
    end
  end

  // Monitor: config shadow, prediction on input transfers, checking on results.
  always @(posedge clk) begin : monitor
    tmt_pkg::out_t want;
    bit            moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          tmt_pkg::CFG_COUNT_DIRECTION: dir_q  = cfg_data[tmt_pkg::DIR_W-1:0];
          tmt_pkg::CFG_CIRCUMFERENCE:   circ_q = cfg_data[tmt_pkg::CIRC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        reading_q.push_back(track_sample(in_data));
        in_xfer_seen = 1'b1;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (reading_q.size() == 0) begin
          $error("reading with nothing predicted: %p", out_data);
          n_mismatch++;
        end else begin
          want = reading_q.pop_front();
          cmp_field("status",      want.status,      out_data.status);
          cmp_field("step_total",  want.step_total,  out_data.step_total);
          cmp_field("turn_count",  want.turn_count,  out_data.turn_count);
          cmp_field("distance_um", want.distance_um, out_data.distance_um);
          cmp_field("noise_limit", want.noise_limit, out_data.noise_limit);
          cmp_field("calibrated",  want.calibrated,  out_data.calibrated);
        end
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
  end

  // Watchdog: no transfer on either side for too long.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int                          ph, i, k, r, step, sty, spread;
    bit                          ok;
    logic [tmt_pkg::ANGLE_W-1:0] pos, ang, center, db;
    logic [tmt_pkg::DIR_W-1:0]   dir_v;
    logic [tmt_pkg::CIRC_W-1:0]  circ_v;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_write(tmt_pkg::CFG_COUNT_DIRECTION,
              {{(tmt_pkg::CFG_DATA_W-tmt_pkg::DIR_W){1'b0}}, DIR_FWD});
    cfg_write(tmt_pkg::CFG_CIRCUMFERENCE, '1);

    // Calibration. Leading fail and failed re-zero leave no reference, so
    // the first calibration sample takes it. The noise profile is picked at
    // random: wide (saturated deadband), flat (minimum deadband) or narrow.
    sty    = $urandom_range(0, 15);
    center = any_angle();
    spread = $urandom_range(1, 60);
    sample_q.push_back(sample_item(1'b0, 1'b0, any_angle()));
    sample_q.push_back(sample_item(1'b1, 1'b0, any_angle()));
    for (i = 0; i < CAL_N; i++) begin
      if (i == 10) sample_q.push_back(sample_item(1'b1, 1'b1, any_angle()));
      if (i == 20) sample_q.push_back(sample_item(1'b0, 1'b0, any_angle()));
      if (sty == 0) begin
        ang = i[0] ? '1 : '0;
      end else if (sty <= 2) begin
        ang = center;
      end else begin
        step = $urandom_range(0, spread);
        if ($urandom_range(0, 1)) step = -step;
        ang = center + step[tmt_pkg::ANGLE_W-1:0];
      end
      sample_q.push_back(sample_item(1'b0, 1'b1, ang));
    end
    // this one closes calibration and is tracked in the same transfer
    sample_q.push_back(sample_item(1'b0, 1'b1, center));
    wait_idle();
    db = trk_deadband;

    // Directed tracking: reference pickup, half-turn edges, wraps kept and
    // dropped by the deadband, deadband edge, failed read, re-zero.
    sample_q.push_back(sample_item(1'b1, 1'b0, any_angle()));
    sample_q.push_back(sample_item(1'b0, 1'b1, '0));       // becomes reference
    sample_q.push_back(sample_item(1'b0, 1'b1, 14'd8192)); // +half, no unwrap
    sample_q.push_back(sample_item(1'b0, 1'b1, '0));       // -half, no unwrap
    sample_q.push_back(sample_item(1'b0, 1'b1, '1));       // wrap below deadband
    ang = '0 - db;
    sample_q.push_back(sample_item(1'b0, 1'b1, ang));      // backward wrap
    sample_q.push_back(sample_item(1'b0, 1'b1, '0));       // forward wrap
    ang = db - 1'b1;
    sample_q.push_back(sample_item(1'b0, 1'b1, ang));      // just under deadband
    sample_q.push_back(sample_item(1'b0, 1'b1, db));       // exactly deadband
    sample_q.push_back(sample_item(1'b0, 1'b0, '1));
    sample_q.push_back(sample_item(1'b1, 1'b1, '1));
    sample_q.push_back(sample_item(1'b0, 1'b1, '0));
    // sender holds off until every reading is back
    wait_idle();

    // Random phases, one register setting each; the last runs without idling.
    pos = '0;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          dir_v  = DIR_BWD;
          circ_v = '1;
        end
        1: begin
          dir_v  = DIR_ZERO;
          circ_v = '0;
        end
        2: begin
          dir_v  = DIR_FWD;
          circ_v = tmt_pkg::CIRC_W'($urandom_range(2, 262142));
        end
        3: begin
          dir_v  = DIR_BWD;
          circ_v = 18'd1;
        end
        default: begin
          dir_v      = DIR_FWD;
          circ_v     = tmt_pkg::CIRC_W'($urandom_range(2, 262142));
          quiet_tail = 1'b1;
        end
      endcase
      cfg_write(tmt_pkg::CFG_COUNT_DIRECTION,
                {{(tmt_pkg::CFG_DATA_W-tmt_pkg::DIR_W){1'b0}}, dir_v});
      cfg_write(tmt_pkg::CFG_CIRCUMFERENCE, circ_v);
      for (i = 0; i < 125; i++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          sample_q.push_back(sample_item(1'b0, 1'b0, any_angle()));
        end else if (r < 10) begin
          ok  = ($urandom_range(0, 3) != 0);
          ang = any_angle();
          sample_q.push_back(sample_item(1'b1, ok, ang));
          if (ok) pos = ang;
        end else if (r < 14) begin
          pos = any_angle();  // jump anywhere
          sample_q.push_back(sample_item(1'b0, 1'b1, pos));
        end else begin
          // wheel motion: jitter around the deadband, moderate, near half a turn
          k = $urandom_range(0, 9);
          if (k < 5) step = $urandom_range(0, 2 * db);
          else if (k < 8) step = $urandom_range(0, 2000);
          else if (k == 8) step = $urandom_range(7000, 8192);
          else step = $urandom_range(8191, 8193);
          if ($urandom_range(0, 1)) step = -step;
          pos = pos + step[tmt_pkg::ANGLE_W-1:0];
          sample_q.push_back(sample_item(1'b0, 1'b1, pos));
        end
      end
      wait_idle();
    end

    // drain margin after the last reading is back
    repeat (40) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
